[rtl/core/ilpd_pkg.sv]
// ----------------------------------------------------------------------------
// ilpd_pkg: shared constants for the interrupt latch and dispatch block
// Event codes, status flag bit positions and fixed field widths.
// ----------------------------------------------------------------------------
`default_nettype none

package ilpd_pkg;

  localparam int EV_W   = 2;
  localparam int PC_W   = 32;
  localparam int FLAG_W = 3;

  // Event codes carried on the input side-band
  localparam logic [EV_W-1:0] EV_NONE  = 2'd0;
  localparam logic [EV_W-1:0] EV_RESET = 2'd1;
  localparam logic [EV_W-1:0] EV_EVAL  = 2'd2;

  // Status flag bit positions
  localparam int FLAG_DISABLE = 0;
  localparam int FLAG_CAI     = 1;
  localparam int FLAG_KERNEL  = 2;

  localparam logic [FLAG_W-1:0] FLAG_ALL = 3'b111;

  // Vector table stride is four bytes
  localparam int VEC_SHIFT = 2;

endpackage

`default_nettype wire

[rtl/core/ilpd_core.sv]
// ----------------------------------------------------------------------------
// ilpd_core: interrupt state and single-pass dispatch logic
// Holds latch, in-service, pending-acknowledge, flag, return and mask
// registers, and computes the result of one transaction combinationally.
// ----------------------------------------------------------------------------
`default_nettype none

module ilpd_core
  import ilpd_pkg::*;
#(
  parameter int NUM_LINES = 10
) (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  step,
  input  wire [EV_W-1:0]       event_req,
  input  wire [PC_W-1:0]       pc,
  input  wire [NUM_LINES-1:0]  raise_bits,
  input  wire [NUM_LINES-1:0]  ack_clear_bits,
  input  wire [NUM_LINES-1:0]  service_release_bits,
  input  wire                  release_disable,
  input  wire                  cfg_wr_en,
  input  wire [NUM_LINES-1:0]  cfg_wr_data,
  output logic [PC_W-1:0]      next_pc,
  output logic                 taken,
  output logic [PC_W-1:0]      return_address,
  output logic [NUM_LINES-1:0] latched,
  output logic [NUM_LINES-1:0] in_service,
  output logic [FLAG_W-1:0]    status_flags
);

  localparam int IDX_W = (NUM_LINES > 1) ? $clog2(NUM_LINES) : 1;

  logic [NUM_LINES-1:0] interrupt_mask;
  logic [NUM_LINES-1:0] latch_reg;
  logic [NUM_LINES-1:0] service_reg;
  logic [NUM_LINES-1:0] ack_pending_reg;
  logic [FLAG_W-1:0]    flag_bits;
  logic [PC_W-1:0]      return_reg;

  logic [NUM_LINES-1:0] latch_next;
  logic [NUM_LINES-1:0] service_next;
  logic [NUM_LINES-1:0] ack_pending_next;
  logic [FLAG_W-1:0]    flag_bits_next;
  logic [PC_W-1:0]      return_next;
  logic [NUM_LINES-1:0] mask_next;

  logic [NUM_LINES-1:0] latch_m;
  logic [NUM_LINES-1:0] ack_m;
  logic [NUM_LINES-1:0] service_m;
  logic [FLAG_W-1:0]    flags_m;
  logic [NUM_LINES-1:0] cand;
  logic [NUM_LINES-1:0] win_oh;
  logic [NUM_LINES-1:0] le_win;
  logic [IDX_W-1:0]     win_idx;
  logic                 blocked;
  logic                 dispatch;

  // Merge this transaction's line updates first
  always_comb begin
    latch_m   = latch_reg | raise_bits;
    ack_m     = ack_pending_reg | ack_clear_bits;
    service_m = service_reg & ~service_release_bits;
    flags_m   = flag_bits;
    if (release_disable) begin
      flags_m[FLAG_DISABLE] = 1'b0;
    end
  end

  // Lowest-numbered candidate wins; blocked if any line at or below it is in service
  always_comb begin
    cand    = latch_m & ~interrupt_mask & ~service_m;
    win_oh  = cand & (~cand + NUM_LINES'(1));
    le_win  = win_oh | (win_oh - NUM_LINES'(1));
    blocked = |(service_m & le_win);
    win_idx = '0;
    for (int i = NUM_LINES - 1; i >= 0; i--) begin
      if (cand[i]) begin
        win_idx = IDX_W'(i);
      end
    end
    dispatch = (event_req == EV_EVAL) && !flags_m[FLAG_DISABLE] && (|cand) && !blocked;
  end

  always_comb begin
    latch_next       = latch_m;
    service_next     = service_m;
    ack_pending_next = ack_m;
    flag_bits_next   = flags_m;
    return_next      = return_reg;
    mask_next        = interrupt_mask;
    next_pc          = pc;
    taken            = 1'b0;
    case (event_req)
      EV_RESET: begin
        latch_next       = '0;
        service_next     = '0;
        ack_pending_next = '0;
        flag_bits_next   = '0;
        return_next      = '0;
        mask_next        = '0;
        next_pc          = '0;
      end
      EV_EVAL: begin
        if (dispatch) begin
          return_next    = pc;
          next_pc        = PC_W'(win_idx) << VEC_SHIFT;
          flag_bits_next = FLAG_ALL;
          service_next   = service_m | win_oh;
          taken          = 1'b1;
        end
        // Pending acknowledges clear the latch on every evaluation
        latch_next       = latch_m & ~(dispatch ? win_oh : '0) & ~ack_m;
        ack_pending_next = '0;
      end
      default: begin
      end
    endcase
  end

  assign return_address = return_next;
  assign latched        = latch_next;
  assign in_service     = service_next;
  assign status_flags   = flag_bits_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      interrupt_mask  <= '0;
      latch_reg       <= '0;
      service_reg     <= '0;
      ack_pending_reg <= '0;
      flag_bits       <= '0;
      return_reg      <= '0;
    end else if (step) begin
      interrupt_mask  <= mask_next;
      latch_reg       <= latch_next;
      service_reg     <= service_next;
      ack_pending_reg <= ack_pending_next;
      flag_bits       <= flag_bits_next;
      return_reg      <= return_next;
    end else if (cfg_wr_en) begin
      interrupt_mask  <= cfg_wr_data;
    end
  end

endmodule

`default_nettype wire

[rtl/core/interrupt_latch_priority_dispatch_top.sv]
// ----------------------------------------------------------------------------
// interrupt_latch_priority_dispatch_top: priority interrupt controller
//
//   channel   direction  handshake                    payload
//   s_axis    in         s_axis_tvalid/s_axis_tready  tdata, tuser (event_req)
//   m_axis    out        m_axis_tvalid/m_axis_tready  tdata
//   cfg       in         cfg_wr_en                    cfg_wr_data (interrupt_mask)
//
// One transaction per cycle sustained while the output is not stalled; a result
// passes through the input register, then the result register.
// The state registers update in one pass, when the input register hands its
// transaction to the result register.
// Reset (rst, synchronous) clears all state, the mask and both valid flags.
// A stalled output holds the result while one more transaction is taken in.
// ----------------------------------------------------------------------------
`default_nettype none

module interrupt_latch_priority_dispatch_top
  import ilpd_pkg::*;
#(
  parameter int NUM_LINES = 10
) (
  input  wire                         clk,
  input  wire                         rst,
  input  wire                         s_axis_tvalid,
  output logic                        s_axis_tready,
  // pc, raise_bits, ack_clear_bits, service_release_bits, release_disable
  input  wire [((PC_W + 3*NUM_LINES + 1 + 7) / 8) * 8 - 1:0] s_axis_tdata,
  // event_req
  input  wire [EV_W-1:0]              s_axis_tuser,
  output logic                        m_axis_tvalid,
  input  wire                         m_axis_tready,
  // next_pc, taken, return_address, latched, in_service, status_flags
  output logic [((2*PC_W + 2*NUM_LINES + 1 + FLAG_W + 7) / 8) * 8 - 1:0] m_axis_tdata,
  input  wire                         cfg_wr_en,
  input  wire [NUM_LINES-1:0]         cfg_wr_data
);

  localparam int IN_W        = PC_W + 3 * NUM_LINES + 1;
  localparam int OUT_W       = 2 * PC_W + 2 * NUM_LINES + 1 + FLAG_W;
  localparam int OUT_TDATA_W = ((OUT_W + 7) / 8) * 8;

  // Input register
  logic                 in_valid;
  logic [EV_W-1:0]      in_event;
  logic [IN_W-1:0]      in_data;

  // Result register
  logic                 out_valid;
  logic [PC_W-1:0]      out_next_pc;
  logic                 out_taken;
  logic [PC_W-1:0]      out_return;
  logic [NUM_LINES-1:0] out_latched;
  logic [NUM_LINES-1:0] out_in_service;
  logic [FLAG_W-1:0]    out_flags;

  logic                 fire;
  logic [PC_W-1:0]      core_next_pc;
  logic                 core_taken;
  logic [PC_W-1:0]      core_return;
  logic [NUM_LINES-1:0] core_latched;
  logic [NUM_LINES-1:0] core_in_service;
  logic [FLAG_W-1:0]    core_flags;

  assign fire          = in_valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = !in_valid || fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_event <= s_axis_tuser;
      in_data  <= s_axis_tdata[IN_W-1:0];
    end
  end

  ilpd_core #(
    .NUM_LINES (NUM_LINES)
  ) u_core (
    .clk                  (clk),
    .rst                  (rst),
    .step                 (fire),
    .event_req            (in_event),
    .pc                   (in_data[PC_W-1:0]),
    .raise_bits           (in_data[PC_W +: NUM_LINES]),
    .ack_clear_bits       (in_data[PC_W + NUM_LINES +: NUM_LINES]),
    .service_release_bits (in_data[PC_W + 2*NUM_LINES +: NUM_LINES]),
    .release_disable      (in_data[IN_W-1]),
    .cfg_wr_en            (cfg_wr_en),
    .cfg_wr_data          (cfg_wr_data),
    .next_pc              (core_next_pc),
    .taken                (core_taken),
    .return_address       (core_return),
    .latched              (core_latched),
    .in_service           (core_in_service),
    .status_flags         (core_flags)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_next_pc    <= core_next_pc;
      out_taken      <= core_taken;
      out_return     <= core_return;
      out_latched    <= core_latched;
      out_in_service <= core_in_service;
      out_flags      <= core_flags;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = OUT_TDATA_W'({out_flags, out_in_service, out_latched,
                                       out_return, out_taken, out_next_pc});

  // A dispatch always leaves all flags set and at least one line in service
  a_taken_flags: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_taken |-> (out_flags == FLAG_ALL) && (out_in_service != '0))
    else $error("dispatch result without full flags or in-service line");

  // Input side only stalls when both registers are full and the output is held
  a_ready_stall: assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> in_valid && out_valid && !m_axis_tready)
    else $error("input stalled without backpressure");

  // A reset event produces an all-clear result
  a_reset_event: assert property (@(posedge clk) disable iff (rst)
    fire && (in_event == EV_RESET) |=>
      (out_next_pc == '0) && !out_taken && (out_latched == '0) && (out_flags == '0))
    else $error("reset event did not clear result");

endmodule

`default_nettype wire
